>>> sv/pal_pkg.sv
// Package for the positional array list: sizes, operation codes, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package pal_pkg;

  localparam int CAPACITY   = 64;
  localparam int ITEM_WIDTH = 32;

  // Port widths fixed by the interface.
  localparam int OP_W  = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int CNT_OUT_W = 7;

  // Internal widths derived from the capacity.
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_WR_ITEM,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic rd_entry;
    logic wr_item;
    logic rd_move;
    logic wr_move;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic ins_go;
    logic rem_go;
    logic rd_go;
    logic wr_go;
    logic ins_direct;
    logic rem_direct;
    logic move_last;
    logic is_insert;
  } status_t;

endpackage

`default_nettype wire

>>> sv/pal_ctrl.sv
// Controller of the positional array list: request handshake, sequencing
// of the entry moves and the result handshake. Depends on pal_pkg.
`default_nettype none

module pal_ctrl
  import pal_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  wire     out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_FINISH;
        if (status.ins_go) begin
          if (status.ins_direct) begin
            cmd.wr_item = 1'b1;
          end else begin
            state_next = S_MOVE_RD;
          end
        end else if (status.rem_go) begin
          if (!status.rem_direct) begin
            state_next = S_MOVE_RD;
          end
        end else if (status.rd_go) begin
          cmd.rd_entry = 1'b1;
        end else if (status.wr_go) begin
          cmd.wr_item = 1'b1;
        end
      end
      S_MOVE_RD: begin
        cmd.rd_move = 1'b1;
        state_next  = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd.wr_move = 1'b1;
        if (status.move_last) begin
          state_next = status.is_insert ? S_WR_ITEM : S_FINISH;
        end else begin
          state_next = S_MOVE_RD;
        end
      end
      S_WR_ITEM: begin
        cmd.wr_item = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/pal_datapath.sv
// Datapath of the positional array list: request registers, entry memory,
// move index, length counter and result registers. Depends on pal_pkg.
`default_nettype none

module pal_datapath
  import pal_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  wire [OP_W-1:0]       operation,
  input  wire [POS_W-1:0]      position,
  input  wire [VAL_W-1:0]      item_value,
  output logic                 ok,
  output logic [VAL_W-1:0]     read_value,
  output logic [CNT_OUT_W-1:0] item_count,
  output logic                 is_empty
);

  logic [OP_W-1:0]       op_q;
  logic [POS_W-1:0]      pos_q;
  logic [ITEM_WIDTH-1:0] item_q;
  logic [CNT_W-1:0]      count;
  logic [IDX_W-1:0]      idx;
  logic                  ok_q;
  logic [ITEM_WIDTH-1:0] rdata;
  logic [ITEM_WIDTH-1:0] mem [CAPACITY];

  logic [CMP_W-1:0]      pos_c, cnt_c, pm1;
  logic [IDX_W-1:0]      pidx;
  logic                  pos_nz, acc_range;
  logic                  we, re;
  logic [IDX_W-1:0]      waddr, raddr;
  logic [ITEM_WIDTH-1:0] wdata;
  logic [CNT_W-1:0]      count_next;
  logic [ITEM_WIDTH+VAL_W-1:0] item_ext, rd_ext;
  logic [CNT_W+CNT_OUT_W-1:0]  cnt_ext;

  assign pos_c     = CMP_W'(pos_q);
  assign cnt_c     = CMP_W'(count);
  assign pm1       = pos_c - CMP_W'(1);
  assign pidx      = pm1[IDX_W-1:0];
  assign pos_nz    = (pos_q != '0);
  assign acc_range = pos_nz && (pos_c <= cnt_c);

  always_comb begin
    status            = '0;
    status.is_insert  = (op_q == OP_INSERT);
    status.ins_go     = status.is_insert && pos_nz && (pos_c <= cnt_c + CMP_W'(1))
                        && (cnt_c < CMP_W'(CAPACITY));
    status.rem_go     = (op_q == OP_REMOVE) && acc_range;
    status.rd_go      = (op_q == OP_READ) && acc_range;
    status.wr_go      = (op_q == OP_WRITE) && acc_range;
    status.ins_direct = (pos_c == cnt_c + CMP_W'(1));
    status.rem_direct = (pos_c == cnt_c);
    if (status.is_insert) begin
      status.move_last = ((idx - IDX_W'(1)) == pidx);
    end else begin
      status.move_last = ((CMP_W'(idx) + CMP_W'(2)) == cnt_c);
    end
  end

  // Memory port control: one write and one registered read per cycle.
  assign item_ext = {{VAL_W{1'b0}}, item_value};
  assign we       = cmd.wr_item || cmd.wr_move;
  assign waddr    = cmd.wr_item ? pidx : idx;
  assign wdata    = cmd.wr_item ? item_q : rdata;
  assign re       = cmd.rd_entry || cmd.rd_move;

  always_comb begin
    if (cmd.rd_entry) begin
      raddr = pidx;
    end else if (status.is_insert) begin
      raddr = idx - IDX_W'(1);
    end else begin
      raddr = idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    count_next = count;
    if (ok_q) begin
      case (op_q)
        OP_INSERT: count_next = count + CNT_W'(1);
        OP_REMOVE: count_next = count - CNT_W'(1);
        OP_CLEAR:  count_next = '0;
        default:   count_next = count;
      endcase
    end
  end

  assign rd_ext  = {{VAL_W{1'b0}}, rdata};
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= operation;
      pos_q  <= position;
      item_q <= item_ext[ITEM_WIDTH-1:0];
    end
    if (cmd.decode) begin
      ok_q <= status.ins_go || status.rem_go || status.rd_go || status.wr_go
              || (op_q == OP_CLEAR);
      idx  <= status.is_insert ? count[IDX_W-1:0] : pidx;
    end else if (cmd.wr_move) begin
      idx  <= status.is_insert ? idx - IDX_W'(1) : idx + IDX_W'(1);
    end
    if (cmd.finish) begin
      ok         <= ok_q;
      read_value <= (ok_q && (op_q == OP_READ)) ? rd_ext[VAL_W-1:0] : '0;
      item_count <= cnt_ext[CNT_OUT_W-1:0];
      is_empty   <= (count_next == '0);
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    CNT_W'(CAPACITY) >= count)
    else $error("list length above capacity");

  a_one_write : assert property (@(posedge clk) disable iff (rst)
    cmd.wr_move |-> !cmd.wr_item)
    else $error("two memory writes in one cycle");

  a_clear_empties : assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && (op_q == OP_CLEAR)) |=> (count == '0) && is_empty)
    else $error("clear left items in the list");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && ok_q && (op_q == OP_INSERT)) |=> (count == $past(count) + CNT_W'(1)))
    else $error("successful insert did not grow the list");

endmodule

`default_nettype wire

>>> sv/positional_array_list.sv
// Top level of the positional array list: joins the controller and the
// datapath. Depends on pal_pkg, pal_ctrl and pal_datapath.
// A request goes from idle to decode; an insert or remove moving entries
// then reads and writes each one in turn through the single entry memory,
// and such an insert then writes its item. The finish state waits while the
// last result is unaccepted; a new request is taken only back in idle.
// Reset clears the length and the handshake state; stored entries are not
// cleared, and none is reachable before it is written.
`default_nettype none

module positional_array_list
  import pal_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire [OP_W-1:0]       operation,
  input  wire [POS_W-1:0]      position,
  input  wire [VAL_W-1:0]      item_value,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic                 ok,
  output logic [VAL_W-1:0]     read_value,
  output logic [CNT_OUT_W-1:0] item_count,
  output logic                 is_empty
);

  // The controller walks each request through decode, the entry moves and
  // the result write; the datapath holds the list and reports where the
  // request stands.
  cmd_t    cmd;
  status_t status;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The result registers live in the datapath, so a new request can be
  // taken while the previous result still waits for the consumer.
  pal_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .operation  (operation),
    .position   (position),
    .item_value (item_value),
    .ok         (ok),
    .read_value (read_value),
    .item_count (item_count),
    .is_empty   (is_empty)
  );

endmodule

`default_nettype wire
